[hdl/sorted_key_table_search_core_assert.svh]
// Assertion macros shared by the sorted key table search core.
`ifndef SORTED_KEY_TABLE_SEARCH_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SKTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/skts_pkg.sv]
// Types and constants shared by the sorted key table search core.
package skts_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 6;
   localparam int STATUS_W = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [POS_W-1:0]  position;
   } search_result_type;

endpackage

[hdl/skts_cell.sv]
// One cell of the sorted key chain: holds one key, shifts on insert, compares on search.
module skts_cell
   import skts_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int CELL_INDEX  = 0
) (
   input  logic                              clock,
   input  logic                              insert_en,
   input  logic                              compare_en,
   input  logic [KEY_W-1:0]                  key,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
   input  logic [KEY_W-1:0]                  prev_key,
   input  logic                              prev_gt,
   output logic [KEY_W-1:0]                  key_out,
   output logic                              gt_out,
   output logic                              lt_flag,
   output logic                              eq_flag
);

   localparam int CW = $clog2(TABLE_DEPTH+1);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             lt_ff;
   logic             lt_in;
   logic             eq_ff;
   logic             eq_in;
   logic             occupied;
   logic             at_end;

   assign occupied = CW'(CELL_INDEX) < count;
   assign at_end   = CW'(CELL_INDEX) == count;
   assign gt_out   = occupied && (key_ff > key);
   assign key_out  = key_ff;
   assign lt_flag  = lt_ff;
   assign eq_flag  = eq_ff;

   always_comb begin
      key_in = key_ff;
      if (insert_en) begin
         if (prev_gt) begin
            key_in = prev_key;
         end else if (gt_out || at_end) begin
            key_in = key;
         end
      end
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (compare_en) begin
         lt_in = key_ff < key;
         eq_in = key_ff == key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

endmodule

[hdl/skts_search.sv]
// Binary search sequencer that probes the cells' compare flags one index per cycle.
module skts_search
   import skts_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
   input  logic [TABLE_DEPTH-1:0]            lt_vec,
   input  logic [TABLE_DEPTH-1:0]            eq_vec,
   output search_result_type                 result
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH+1);

   logic          busy_ff;
   logic          busy_in;
   logic [CW-1:0] lo_ff;
   logic [CW-1:0] lo_in;
   logic [CW-1:0] hi_ff;
   logic [CW-1:0] hi_in;
   logic [CW-1:0] mid;
   logic          crossed;
   logic          probe_lt;
   logic          probe_eq;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign crossed  = lo_ff > hi_ff;
   assign probe_lt = lt_vec[mid[IW-1:0]];
   assign probe_eq = eq_vec[mid[IW-1:0]];

   always_comb begin
      result.done     = busy_ff && (crossed || probe_eq || (!probe_lt && (mid == '0)));
      result.found    = busy_ff && !crossed && probe_eq;
      result.position = result.found ? POS_W'(mid) : '0;
   end

   always_comb begin
      busy_in = busy_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      if (start) begin
         busy_in = 1'b1;
         if (count == '0) begin
            lo_in = CW'(1);
            hi_in = '0;
         end else begin
            lo_in = '0;
            hi_in = count - CW'(1);
         end
      end else if (busy_ff) begin
         if (result.done) begin
            busy_in = 1'b0;
         end else if (probe_lt) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

endmodule

[hdl/sorted_key_table_search_core.sv]
// Top level of the sorted key table search core: cell chain, search sequencer and control.
// The block keeps up to TABLE_DEPTH 32-bit keys in a chain of cells held in ascending order.
// Request beats carry the key on req_tdata and the operation on req_tuser (0 insert,
// 1 search). Each request beat yields exactly one response beat on rsp_tdata holding the
// status in bits 1:0 and the matching sorted position in bits 7:2.
// An insert shifts the larger keys one cell up and drops the new key into place in the
// cycle it is accepted. Its status is registered and then loaded into the output register
// from the respond state, before the next request is taken. A full table answers with the
// full status and stores nothing.
// A search compares the key against every cell in the accept cycle. The binary search then
// probes one index per cycle, up to clog2(TABLE_DEPTH+1) probes, and the result is
// registered as status and position, then loaded into the response register from the
// respond state. One request is in flight at a time.
// The next request is taken as soon as the response sits in the output register, even if
// the receiver has not yet taken it; a stalled receiver holds that beat and, once the next
// result is done, the block waits with req_tready low until the output register frees up.
// A synchronous reset empties the table and drops any pending response; no clearing pass
// is needed, since only cells below the entry count are ever used.
`include "sorted_key_table_search_core_assert.svh"

module sorted_key_table_search_core
   import skts_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // Bits 31:0 key.
   input  logic [0:0]   req_tuser,   // Bit 0 func.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata    // Bits 1:0 status, bits 7:2 position.
);

   localparam int CW = $clog2(TABLE_DEPTH+1);

   state_type          state_ff;
   state_type          state_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   status_type         status_ff;
   status_type         status_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_data_ff;
   logic [7:0]         rsp_data_in;

   logic               accept;
   logic               full;
   logic               insert_en;
   logic               search_start;
   logic               load_rsp;
   search_result_type  search_res;

   logic [KEY_W-1:0]       cell_key [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_gt;
   logic [TABLE_DEPTH-1:0] lt_vec;
   logic [TABLE_DEPTH-1:0] eq_vec;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         logic [KEY_W-1:0] prev_key;
         logic             prev_gt;
         if (gi == 0) begin : g_first
            assign prev_key = '0;
            assign prev_gt  = 1'b0;
         end else begin : g_rest
            assign prev_key = cell_key[gi-1];
            assign prev_gt  = cell_gt[gi-1];
         end
         skts_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_INDEX  (gi)
         ) u_cell (
            .clock      (clock),
            .insert_en  (insert_en),
            .compare_en (search_start),
            .key        (req_tdata),
            .count      (count_ff),
            .prev_key   (prev_key),
            .prev_gt    (prev_gt),
            .key_out    (cell_key[gi]),
            .gt_out     (cell_gt[gi]),
            .lt_flag    (lt_vec[gi]),
            .eq_flag    (eq_vec[gi])
         );
      end
   endgenerate

   skts_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (search_start),
      .count  (count_ff),
      .lt_vec (lt_vec),
      .eq_vec (eq_vec),
      .result (search_res)
   );

   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      accept       = req_tvalid && req_tready;
      full         = (count_ff == CW'(TABLE_DEPTH));
      insert_en    = accept && (req_tuser[0] == FUNC_INSERT) && !full;
      search_start = accept && (req_tuser[0] == FUNC_SEARCH);
      load_rsp     = (state_ff == S_RESPOND) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_tuser[0] == FUNC_SEARCH) ? S_SEARCH : S_RESPOND;
            end
         end
         S_SEARCH: begin
            if (search_res.done) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = insert_en ? count_ff + CW'(1) : count_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && (req_tuser[0] == FUNC_INSERT)) begin
         status_in = full ? ST_FULL : ST_INSERTED;
         pos_in    = '0;
      end else if ((state_ff == S_SEARCH) && search_res.done) begin
         status_in = search_res.found ? ST_FOUND : ST_NOT_FOUND;
         pos_in    = search_res.position;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {pos_ff, status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SKTS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(TABLE_DEPTH), "Entry count exceeds table depth.")
   `SKTS_ASSERT_NEXT(a_insert_grows, insert_en, count_ff == $past(count_ff) + CW'(1), "Insert did not grow the table.")
   `SKTS_ASSERT_NOW(a_done_in_search, search_res.done, state_ff == S_SEARCH, "Search finished outside the search state.")
   `SKTS_ASSERT_NOW(a_chain_sorted, count_ff >= CW'(2), cell_key[0] <= cell_key[1], "Lowest cells are out of order.")

endmodule
